[rtl/pib_pkg.sv]
package pib_pkg;

    // fixed point fraction bits
    localparam int FRAC_BITS = 16;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_STEP       = 8'd0,
        REG_GRAVITY_ACCEL   = 8'd1,
        REG_RESTITUTION     = 8'd2,
        REG_PARTICLE_RADIUS = 8'd3,
        REG_BOX_MIN_X       = 8'd4,
        REG_BOX_MAX_X       = 8'd5,
        REG_BOX_MIN_Y       = 8'd6,
        REG_BOX_MAX_Y       = 8'd7
    } cfg_reg_t;

    localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] I32_MIN = -64'sd2147483648;

    // one particle as it enters
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
    } pib_in_t;

    // one updated particle
    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
    } pib_out_t;

    // particle after the velocity update, queued between front and back
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } pib_mid_t;

    // register file contents
    typedef struct packed {
        logic        [30:0] time_step;
        logic signed [31:0] gravity_accel;
        logic        [16:0] restitution;
        logic        [30:0] particle_radius;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_max_y;
    } pib_cfg_t;

    // clamp a wide value to the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > I32_MAX)
            return I32_MAX[31:0];
        else if (v < I32_MIN)
            return I32_MIN[31:0];
        else
            return v[31:0];
    endfunction

    // saturating 32 bit add
    function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [63:0] s;
        s = 64'(a) + 64'(b);
        return sat32(s);
    endfunction

endpackage

[rtl/pib_fifo.sv]
module pib_fifo #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/pib_front.sv]
module pib_front import pib_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  pib_cfg_t cfg,
    input  logic     push,
    output logic     full,
    input  pib_in_t  particle,
    output logic     mid_push,
    output pib_mid_t mid_data,
    input  logic     mid_full
);

    logic                a_valid_reg;
    logic signed [31:0]  a_pos_x_reg;
    logic signed [31:0]  a_pos_y_reg;
    logic signed [31:0]  a_vel_x_reg;
    logic signed [31:0]  a_vel_y_reg;
    logic signed [63:0]  a_gdt_reg;
    logic signed [63:0]  a_axdt_reg;
    logic signed [63:0]  a_aydt_reg;

    logic signed [31:0]  dt_s;
    logic signed [63:0]  gdt;
    logic signed [63:0]  axdt;
    logic signed [63:0]  aydt;
    logic                accept;
    logic signed [31:0]  vel_y_grav;

    assign dt_s   = $signed({1'b0, cfg.time_step});
    assign full   = a_valid_reg && mid_full;
    assign accept = push && !full;

    // products against the time step, registered at accept
    assign gdt  = cfg.gravity_accel * dt_s;
    assign axdt = particle.acc_x * dt_s;
    assign aydt = particle.acc_y * dt_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (mid_push)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_pos_x_reg <= particle.pos_x;
            a_pos_y_reg <= particle.pos_y;
            a_vel_x_reg <= particle.vel_x;
            a_vel_y_reg <= particle.vel_y;
            a_gdt_reg   <= gdt;
            a_axdt_reg  <= axdt;
            a_aydt_reg  <= aydt;
        end
    end

    // velocity update: gravity first, then the particle acceleration
    assign vel_y_grav = sat_add32(a_vel_y_reg, sat32(a_gdt_reg >>> FRAC_BITS));

    always_comb
    begin
        mid_data.pos_x = a_pos_x_reg;
        mid_data.pos_y = a_pos_y_reg;
        mid_data.vel_x = sat_add32(a_vel_x_reg, sat32(a_axdt_reg >>> FRAC_BITS));
        mid_data.vel_y = sat_add32(vel_y_grav, sat32(a_aydt_reg >>> FRAC_BITS));
    end

    assign mid_push = a_valid_reg && !mid_full;

endmodule

[rtl/pib_back.sv]
module pib_back import pib_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  pib_cfg_t cfg,
    input  logic     mid_empty,
    output logic     mid_pop,
    input  pib_mid_t mid_data,
    output logic     out_push,
    output pib_out_t out_data,
    input  logic     out_full
);

    // stage valids
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_ready, s2_ready, s3_ready;

    // stage 1: position products
    pib_mid_t           s1_item_reg;
    logic signed [63:0] s1_pxdt_reg;
    logic signed [63:0] s1_pydt_reg;

    // stage 2: clamped positions and hit flags
    logic signed [31:0] s2_pos_x_reg, s2_pos_y_reg;
    logic signed [31:0] s2_vel_x_reg, s2_vel_y_reg;
    logic               s2_hit_x_reg, s2_hit_y_reg;

    // stage 3: restitution products
    logic signed [31:0] s3_pos_x_reg, s3_pos_y_reg;
    logic signed [31:0] s3_vel_x_reg, s3_vel_y_reg;
    logic signed [49:0] s3_rvx_reg, s3_rvy_reg;
    logic               s3_hit_x_reg, s3_hit_y_reg;

    logic signed [31:0] dt_s;
    logic signed [17:0] rest_s;
    logic signed [63:0] radius_64;
    logic signed [33:0] radius_34;
    logic signed [31:0] px_raw, py_raw;
    logic signed [31:0] px_new, py_new;
    logic               hit_x, hit_y;
    logic signed [49:0] rvx, rvy;
    logic signed [63:0] neg_rvx, neg_rvy;

    assign dt_s      = $signed({1'b0, cfg.time_step});
    assign rest_s    = $signed({1'b0, cfg.restitution});
    assign radius_64 = $signed({33'b0, cfg.particle_radius});
    assign radius_34 = $signed({3'b0, cfg.particle_radius});

    // ready ripples back from the output queue
    assign s3_ready = !s3_valid_reg || !out_full;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign mid_pop  = !mid_empty && s1_ready;
    assign out_push = s3_valid_reg && !out_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= mid_pop;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // stage 1 load
    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_item_reg <= mid_data;
            s1_pxdt_reg <= mid_data.vel_x * dt_s;
            s1_pydt_reg <= mid_data.vel_y * dt_s;
        end
    end

    // position advance and wall tests; the lower wall is tested first
    always_comb
    begin
        logic signed [33:0] p34;
        px_raw = sat_add32(s1_item_reg.pos_x, sat32(s1_pxdt_reg >>> FRAC_BITS));
        py_raw = sat_add32(s1_item_reg.pos_y, sat32(s1_pydt_reg >>> FRAC_BITS));

        p34    = 34'(px_raw);
        hit_x  = 1'b1;
        if ((p34 - radius_34) < 34'(cfg.box_min_x))
        begin
            px_new = sat32(64'(cfg.box_min_x) + radius_64);
        end
        else if ((p34 + radius_34) > 34'(cfg.box_max_x))
        begin
            px_new = sat32(64'(cfg.box_max_x) - radius_64);
        end
        else
        begin
            px_new = px_raw;
            hit_x  = 1'b0;
        end

        p34    = 34'(py_raw);
        hit_y  = 1'b1;
        if ((p34 - radius_34) < 34'(cfg.box_min_y))
        begin
            py_new = sat32(64'(cfg.box_min_y) + radius_64);
        end
        else if ((p34 + radius_34) > 34'(cfg.box_max_y))
        begin
            py_new = sat32(64'(cfg.box_max_y) - radius_64);
        end
        else
        begin
            py_new = py_raw;
            hit_y  = 1'b0;
        end
    end

    // stage 2 load
    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_pos_x_reg <= px_new;
            s2_pos_y_reg <= py_new;
            s2_vel_x_reg <= s1_item_reg.vel_x;
            s2_vel_y_reg <= s1_item_reg.vel_y;
            s2_hit_x_reg <= hit_x;
            s2_hit_y_reg <= hit_y;
        end
    end

    // restitution times velocity
    assign rvx = rest_s * s2_vel_x_reg;
    assign rvy = rest_s * s2_vel_y_reg;

    // stage 3 load
    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_pos_x_reg <= s2_pos_x_reg;
            s3_pos_y_reg <= s2_pos_y_reg;
            s3_vel_x_reg <= s2_vel_x_reg;
            s3_vel_y_reg <= s2_vel_y_reg;
            s3_rvx_reg   <= rvx;
            s3_rvy_reg   <= rvy;
            s3_hit_x_reg <= s2_hit_x_reg;
            s3_hit_y_reg <= s2_hit_y_reg;
        end
    end

    // reflected velocity: floor of the negated product
    assign neg_rvx = -64'(s3_rvx_reg);
    assign neg_rvy = -64'(s3_rvy_reg);

    always_comb
    begin
        out_data.new_pos_x = s3_pos_x_reg;
        out_data.new_pos_y = s3_pos_y_reg;
        out_data.new_vel_x = s3_hit_x_reg ? sat32(neg_rvx >>> FRAC_BITS) : s3_vel_x_reg;
        out_data.new_vel_y = s3_hit_y_reg ? sat32(neg_rvy >>> FRAC_BITS) : s3_vel_y_reg;
    end

endmodule

[rtl/particle_integrate_and_bounce_unit.sv]
// Channel    Handshake               Payload
// ---------  ----------------------  ------------------------------------
// input      push / full             particle (pib_in_t)
// result     pop / empty             result (pib_out_t)
// config     cfg_valid / cfg_ready   cfg_index (register), cfg_data
//
// One particle per cycle sustained while the result queue is not full; a
// particle passes the front stage, the mid queue, three back stages, then
// the output queue. The front stage holds the velocity products, the back
// stages hold the position products, the wall tests and the restitution
// products. Reset clears queues, stage valids and config; restitution resets
// to one. A full mid queue stalls only the front; a full output queue stalls
// the back, which then fills the mid queue before the front stalls.
module particle_integrate_and_bounce_unit import pib_pkg::*; #(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // input queue side
    input  logic                 push,
    output logic                 full,
    input  pib_in_t              particle,
    // result queue side
    output logic                 empty,
    input  logic                 pop,
    output pib_out_t             result,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam logic [16:0] RESTITUTION_ONE = 17'(1 << FRAC_BITS);

    pib_cfg_t cfg_reg;

    logic     mid_push, mid_pop, mid_full, mid_empty;
    pib_mid_t mid_wr, mid_rd;
    logic     out_push, out_full;
    pib_out_t out_wr;

    // register file
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // step, gravity, restitution, radius, then the four bounds
            cfg_reg <= {31'd0, 32'd0, RESTITUTION_ONE, 31'd0, 128'd0};
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TIME_STEP:       cfg_reg.time_step       <= cfg_data[30:0];
                REG_GRAVITY_ACCEL:   cfg_reg.gravity_accel   <= $signed(cfg_data);
                REG_RESTITUTION:     cfg_reg.restitution     <= cfg_data[16:0];
                REG_PARTICLE_RADIUS: cfg_reg.particle_radius <= cfg_data[30:0];
                REG_BOX_MIN_X:       cfg_reg.box_min_x       <= $signed(cfg_data);
                REG_BOX_MAX_X:       cfg_reg.box_max_x       <= $signed(cfg_data);
                REG_BOX_MIN_Y:       cfg_reg.box_min_y       <= $signed(cfg_data);
                REG_BOX_MAX_Y:       cfg_reg.box_max_y       <= $signed(cfg_data);
                default:             ;
            endcase
        end
    end

    // front: accept and velocity update
    pib_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .full     (full),
        .particle (particle),
        .mid_push (mid_push),
        .mid_data (mid_wr),
        .mid_full (mid_full)
    );

    // queue between front and back
    pib_fifo #(
        .WIDTH ($bits(pib_mid_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (mid_push),
        .wr_data (mid_wr),
        .full    (mid_full),
        .pop     (mid_pop),
        .rd_data (mid_rd),
        .empty   (mid_empty)
    );

    // back: position, walls, bounce
    pib_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .mid_data  (mid_rd),
        .out_push  (out_push),
        .out_data  (out_wr),
        .out_full  (out_full)
    );

    // result queue
    pib_fifo #(
        .WIDTH ($bits(pib_out_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (out_push),
        .wr_data (out_wr),
        .full    (out_full),
        .pop     (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import pib_pkg::*;

    localparam int Q_ONE = 1 << FRAC_BITS;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;
    localparam logic [31:0] STEP_MAX = 32'h7FFFFFFF;
    localparam logic [31:0] REST_MAX = 32'h0001FFFF;
    localparam int GRAVITY_NOMINAL = -642252;
    localparam int MAX_GAP = 11;
    localparam int DRAIN_CYCLES = 12;
    localparam int LIMIT_CYCLES = 250000;

    // one axis after the wall test
    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
    } axis_state_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    pib_in_t particle = '0;
    logic empty;
    logic pop = 1'b0;
    pib_out_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // register contents as the block should hold them
    logic [30:0] cur_time_step = '0;
    logic signed [31:0] cur_gravity = '0;
    logic [16:0] cur_restitution = 17'd65536;
    logic [30:0] cur_radius = '0;
    logic signed [31:0] cur_min_x = '0;
    logic signed [31:0] cur_max_x = '0;
    logic signed [31:0] cur_min_y = '0;
    logic signed [31:0] cur_max_y = '0;

    pib_out_t expected_motion[$];
    int mismatch_count = 0;
    int cycle_count = 0;
    bit sender_idle_on = 1'b1;
    bit reader_idle_on = 1'b1;
    int pop_hold_cycles = 0;

    particle_integrate_and_bounce_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .particle  (particle),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------- prediction ----------------

    function automatic logic signed [31:0] saturate_q16(input longint v);
        if (v > 64'sd2147483647)
            return S32_MAX;
        if (v < -64'sd2147483648)
            return S32_MIN;
        return v[31:0];
    endfunction

    // fixed point product, floor rounding, saturated
    function automatic longint q_mul(input longint a, input longint b);
        return saturate_q16((a * b) >>> FRAC_BITS);
    endfunction

    // lower wall checked first; a hit clamps and reflects the velocity
    function automatic axis_state_t wall_bounce(input longint p, input longint v,
                                                input longint lo, input longint hi);
        longint rad;
        bit hit;
        axis_state_t s;
        rad = longint'(cur_radius);
        hit = 1'b0;
        if (p - rad < lo)
        begin
            p = lo + rad;
            hit = 1'b1;
        end
        else if (p + rad > hi)
        begin
            p = hi - rad;
            hit = 1'b1;
        end
        if (hit)
            v = (-(longint'(cur_restitution) * v)) >>> FRAC_BITS;
        s.pos = saturate_q16(p);
        s.vel = saturate_q16(v);
        return s;
    endfunction

    function automatic pib_out_t integrate_particle(input pib_in_t p);
        longint step, px, py, vx, vy;
        axis_state_t sx, sy;
        pib_out_t r;
        step = longint'(cur_time_step);
        px = $signed(p.pos_x);
        py = $signed(p.pos_y);
        vx = $signed(p.vel_x);
        vy = $signed(p.vel_y);
        vy = saturate_q16(vy + q_mul(cur_gravity, step));
        vx = saturate_q16(vx + q_mul($signed(p.acc_x), step));
        vy = saturate_q16(vy + q_mul($signed(p.acc_y), step));
        px = saturate_q16(px + q_mul(vx, step));
        py = saturate_q16(py + q_mul(vy, step));
        sx = wall_bounce(px, vx, cur_min_x, cur_max_x);
        sy = wall_bounce(py, vy, cur_min_y, cur_max_y);
        r.new_pos_x = sx.pos;
        r.new_pos_y = sy.pos;
        r.new_vel_x = sx.vel;
        r.new_vel_y = sy.vel;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic pib_in_t particle_of(input logic signed [31:0] px, py, vx, vy, ax, ay);
        pib_in_t p;
        p.pos_x = px;
        p.pos_y = py;
        p.vel_x = vx;
        p.vel_y = vy;
        p.acc_x = ax;
        p.acc_y = ay;
        return p;
    endfunction

    function automatic logic signed [31:0] jitter(input longint base, input int unsigned spread);
        return saturate_q16(base + longint'($urandom_range(0, 2 * spread)) - longint'(spread));
    endfunction

    // aim at one of the walls or the middle of the box
    function automatic longint wall_target(input longint lo, input longint hi);
        case ($urandom_range(0, 2))
            0: return lo;
            1: return hi;
            default: return (lo + hi) / 2;
        endcase
    endfunction

    function automatic pib_in_t random_particle();
        pib_in_t p;
        int unsigned mode;
        mode = $urandom_range(0, 9);
        if (mode == 0)
            p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        else
        begin
            p.pos_x = jitter(wall_target(cur_min_x, cur_max_x), 2 * Q_ONE);
            p.pos_y = jitter(wall_target(cur_min_y, cur_max_y), 2 * Q_ONE);
            p.vel_x = jitter(0, 40 * Q_ONE);
            p.vel_y = jitter(0, 40 * Q_ONE);
            p.acc_x = jitter(0, 200 * Q_ONE);
            p.acc_y = jitter(0, 200 * Q_ONE);
            if (mode == 1)
                p.vel_x = $urandom;
            if (mode == 2)
                p.vel_y = $urandom;
        end
        return p;
    endfunction

    // one particle transfer; push stays high into the next call when there is no gap
    task automatic send_particle(input pib_in_t p);
        int gap;
        gap = sender_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        particle <= p;
        do @(posedge clk); while (full);
        expected_motion.push_back(integrate_particle(p));
    endtask

    // one config transfer; cfg_valid is lowered by the caller
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_TIME_STEP:       cur_time_step = data[30:0];
            REG_GRAVITY_ACCEL:   cur_gravity = data;
            REG_RESTITUTION:     cur_restitution = data[16:0];
            REG_PARTICLE_RADIUS: cur_radius = data[30:0];
            REG_BOX_MIN_X:       cur_min_x = data;
            REG_BOX_MAX_X:       cur_max_x = data;
            REG_BOX_MIN_Y:       cur_min_y = data;
            REG_BOX_MAX_Y:       cur_max_y = data;
            default: ;
        endcase
    endtask

    // write every register; unused upper bits carry noise
    task automatic program_config(input logic [31:0] step, grav, rest, radius,
                                  input logic [31:0] lo_x, hi_x, lo_y, hi_y,
                                  input bit add_unused);
        logic [31:0] noise;
        noise = $urandom;
        write_reg(REG_TIME_STEP, {noise[31], step[30:0]});
        write_reg(REG_GRAVITY_ACCEL, grav);
        write_reg(REG_RESTITUTION, {noise[14:0], rest[16:0]});
        write_reg(REG_PARTICLE_RADIUS, {noise[20], radius[30:0]});
        write_reg(REG_BOX_MIN_X, lo_x);
        write_reg(REG_BOX_MAX_X, hi_x);
        write_reg(REG_BOX_MIN_Y, lo_y);
        write_reg(REG_BOX_MAX_Y, hi_y);
        if (add_unused)
            write_reg($urandom_range(REG_BOX_MAX_Y + 1, (1 << CFG_IDX_W) - 1), $urandom);
        cfg_valid <= 1'b0;
    endtask

    task automatic randomize_config(input bit wide);
        logic [31:0] step, grav, rest, radius, lo_x, hi_x, lo_y, hi_y, swap;
        if (wide)
        begin
            case ($urandom_range(0, 2))
                0: step = 0;
                1: step = STEP_MAX;
                default: step = $urandom;
            endcase
            grav = $urandom;
            rest = $urandom_range(0, REST_MAX);
            radius = $urandom;
            lo_x = $urandom;
            hi_x = $urandom;
            lo_y = $urandom;
            hi_y = $urandom;
        end
        else
        begin
            step = $urandom_range(0, Q_ONE);
            grav = jitter(GRAVITY_NOMINAL, 1 << 20);
            rest = $urandom_range(0, 1) ? Q_ONE : $urandom_range(0, REST_MAX);
            radius = $urandom_range(0, Q_ONE);
            lo_x = jitter(-20 * Q_ONE, 10 * Q_ONE);
            hi_x = jitter(20 * Q_ONE, 10 * Q_ONE);
            lo_y = jitter(-20 * Q_ONE, 10 * Q_ONE);
            hi_y = jitter(20 * Q_ONE, 10 * Q_ONE);
            // occasionally an inverted box
            if ($urandom_range(0, 7) == 0)
            begin
                swap = lo_x;
                lo_x = hi_x;
                hi_x = swap;
            end
        end
        program_config(step, grav, rest, radius, lo_x, hi_x, lo_y, hi_y, 1'b1);
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain();
        push <= 1'b0;
        while (expected_motion.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ---------------- result checking ----------------

    task automatic compare_field(input string name, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result(input pib_out_t got);
        pib_out_t want;
        if (expected_motion.size() == 0)
        begin
            $error("result transfer with no particle outstanding");
            mismatch_count++;
            return;
        end
        want = expected_motion.pop_front();
        compare_field("new_pos_x", want.new_pos_x, got.new_pos_x);
        compare_field("new_pos_y", want.new_pos_y, got.new_pos_y);
        compare_field("new_vel_x", want.new_vel_x, got.new_vel_x);
        compare_field("new_vel_y", want.new_vel_y, got.new_vel_y);
    endtask

    // result side: random pops, plus a long hold when requested
    initial
    begin : result_reader
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            if (pop_hold_cycles > 0)
            begin
                pop <= 1'b0;
                repeat (pop_hold_cycles) @(posedge clk);
                pop_hold_cycles = 0;
            end
            gap = reader_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            check_result(result);
        end
    end

    // ---------------- tests ----------------

    // reset values: zero step, zero box, unit restitution
    task automatic test_reset_values();
        send_particle(particle_of(-Q_ONE, 3 * Q_ONE, 5 * Q_ONE, -2 * Q_ONE, Q_ONE, Q_ONE));
        send_particle(particle_of(7, -7, -Q_ONE, Q_ONE, 0, 0));
        send_particle(particle_of(0, 0, 0, 0, 0, 0));
        drain();
    endtask

    task automatic test_nominal_walls();
        program_config(4096, GRAVITY_NOMINAL, 52429, 16384,
                       -10 * Q_ONE, 10 * Q_ONE, -5 * Q_ONE, 15 * Q_ONE, 1'b0);
        send_particle(particle_of(0, 0, 0, 0, 0, 0));
        send_particle(particle_of(Q_ONE, 2 * Q_ONE, Q_ONE / 2, -Q_ONE, 3 * Q_ONE, -7 * Q_ONE));
        // left, right, floor, ceiling hits
        send_particle(particle_of(-9 * Q_ONE - 60000, 0, -20 * Q_ONE, 0, 0, 0));
        send_particle(particle_of(9 * Q_ONE + 60000, 0, 20 * Q_ONE, 0, -Q_ONE, 0));
        send_particle(particle_of(0, -4 * Q_ONE - 60000, 0, -30 * Q_ONE, 0, 0));
        send_particle(particle_of(0, 14 * Q_ONE + 60000, 0, 30 * Q_ONE, 0, 0));
        // resting exactly on a wall is no hit
        send_particle(particle_of(-10 * Q_ONE + 16384, 5 * Q_ONE, 0, 0, 0, 0));
        send_particle(particle_of(10 * Q_ONE - 16384, 5 * Q_ONE, 0, 0, 0, 0));
        // field extremes, saturating sums
        send_particle(particle_of(S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX));
        send_particle(particle_of(S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN));
        send_particle(particle_of(S32_MAX, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MIN));
        drain();
    endtask

    task automatic test_extreme_config();
        // largest step and radius, most negative gravity, inverted x box
        program_config(STEP_MAX, S32_MIN, REST_MAX, STEP_MAX,
                       S32_MAX, S32_MIN, S32_MIN, S32_MAX, 1'b0);
        send_particle(particle_of(0, 0, Q_ONE, Q_ONE, 0, 0));
        send_particle(particle_of(S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MIN, S32_MAX));
        send_particle(particle_of(-5, 5, -Q_ONE, Q_ONE, Q_ONE, -Q_ONE));
        drain();
        // inverted box: lower test wins; restitution above one gains speed
        program_config(0, 0, REST_MAX, Q_ONE, 5 * Q_ONE, -5 * Q_ONE,
                       -100 * Q_ONE, 100 * Q_ONE, 1'b0);
        send_particle(particle_of(0, 0, 3 * Q_ONE, 0, 0, 0));
        send_particle(particle_of(0, 0, 32'sh40000000, 0, 0, 0));
        drain();
        // negating the most negative velocity saturates
        program_config(0, 0, Q_ONE, 0, 0, 0, 0, 0, 1'b0);
        send_particle(particle_of(-1, 1, S32_MIN, S32_MIN, 0, 0));
        send_particle(particle_of(1, -1, S32_MAX, S32_MAX, 0, 0));
        drain();
        // zero restitution stops the particle at the wall
        program_config(Q_ONE, 0, 0, 0, -Q_ONE, Q_ONE, -Q_ONE, Q_ONE, 1'b0);
        send_particle(particle_of(0, 0, 5 * Q_ONE, -5 * Q_ONE, 0, 0));
        drain();
    endtask

    // writes beyond the register list change nothing
    task automatic test_unused_register();
        program_config(8192, GRAVITY_NOMINAL, Q_ONE, 8192,
                       -3 * Q_ONE, 3 * Q_ONE, -3 * Q_ONE, 3 * Q_ONE, 1'b1);
        send_particle(particle_of(2 * Q_ONE, -2 * Q_ONE, 30 * Q_ONE, -30 * Q_ONE, 0, 0));
        send_particle(particle_of(0, 0, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
        drain();
    endtask

    // reader stops for a long stretch so the block fills and stalls its input
    task automatic test_stalled_reader();
        randomize_config(1'b0);
        sender_idle_on = 1'b0;
        reader_idle_on = 1'b1;
        pop_hold_cycles = 80;
        repeat (40) send_particle(random_particle());
        drain();
        sender_idle_on = 1'b1;
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 6; phase++)
        begin
            randomize_config(phase % 3 == 2);
            sender_idle_on = (phase % 4 != 1) && (phase != 3);
            reader_idle_on = (phase % 4 != 2) && (phase != 3);
            repeat (200) send_particle(random_particle());
            drain();
        end
        sender_idle_on = 1'b1;
        reader_idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_nominal_walls();
        test_extreme_config();
        test_unused_register();
        test_stalled_reader();
        test_random_phases();
        drain();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[particle_integrate_and_bounce_unit.f]
rtl/pib_pkg.sv
rtl/pib_fifo.sv
rtl/pib_front.sv
rtl/pib_back.sv
rtl/particle_integrate_and_bounce_unit.sv
tb/testbench.sv
